// ----- rtl/b2i_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2i_pkg
// Shared constants and types of the BGRA to 4:2:0 nearest-neighbor scaler.
// ----------------------------------------------------------------------------
package b2i_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int MAX_STRIDE = 16384;

    localparam int DIM_W    = $clog2(MAX_DIM) + 1;
    localparam int CNT_W    = $clog2(MAX_DIM);
    localparam int STRIDE_W = $clog2(MAX_STRIDE) + 1;
    localparam int OFF_W    = 26;
    localparam int IDX_W    = 24;
    localparam int PIX_W    = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (STRIDE_W > DIM_W) ? STRIDE_W : DIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_STRIDE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd4;

    localparam logic OP_START = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // shared multiplier
    localparam int MUL_A_W = OFF_W;
    localparam int MUL_B_W = STRIDE_W;

    // shared divider: DIV_BITS quotient bits per cycle
    localparam int DIVD_W    = OFF_W;
    localparam int DIVS_W    = DIM_W;
    localparam int DIV_BITS  = 4;
    localparam int DIV_PAD_W = ((DIVD_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int DIV_STEPS = DIV_PAD_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // BT.601 limited-range coefficients
    localparam int CSC_W    = 18;
    localparam int Y_KR     = 66;
    localparam int Y_KG     = 129;
    localparam int Y_KB     = 25;
    localparam int Y_BIAS   = 16;
    localparam int CB_KR    = -38;
    localparam int CB_KG    = -74;
    localparam int CB_KB    = 112;
    localparam int CR_KR    = 112;
    localparam int CR_KG    = -94;
    localparam int CR_KB    = -18;
    localparam int C_BIAS   = 128;
    localparam int ROUND    = 128;

    typedef struct packed {
        logic                start;
        logic [DIVD_W-1:0]   dividend;
        logic [DIVS_W-1:0]   divisor;
    } div_req_t;

endpackage

// ----- rtl/b2i_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2i interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface b2i_req_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [b2i_pkg::PIX_W-1:0]  blue;
    logic [b2i_pkg::PIX_W-1:0]  green;
    logic [b2i_pkg::PIX_W-1:0]  red;

    modport source (output valid, op, blue, green, red, input ready);
    modport sink   (input valid, op, blue, green, red, output ready);
endinterface

interface b2i_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       sample_valid;
    logic                       plane;
    logic [b2i_pkg::IDX_W-1:0]  dest_index;
    logic [b2i_pkg::PIX_W-1:0]  luma;
    logic [b2i_pkg::PIX_W-1:0]  cb;
    logic [b2i_pkg::PIX_W-1:0]  cr;
    logic                       fetch_valid;
    logic [b2i_pkg::OFF_W-1:0]  fetch_offset;
    logic                       frame_done;
    logic                       unexpected;

    modport source (output valid, sample_valid, plane, dest_index, luma, cb, cr,
                    fetch_valid, fetch_offset, frame_done, unexpected,
                    input ready);
    modport sink   (input valid, sample_valid, plane, dest_index, luma, cb, cr,
                    fetch_valid, fetch_offset, frame_done, unexpected,
                    output ready);
endinterface

// ----- rtl/b2i_csc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2i_csc
// BT.601 limited-range RGB to YCbCr conversion by constant coefficients.
// ----------------------------------------------------------------------------
module b2i_csc (
    input  logic [b2i_pkg::PIX_W-1:0] red,
    input  logic [b2i_pkg::PIX_W-1:0] green,
    input  logic [b2i_pkg::PIX_W-1:0] blue,
    output logic [b2i_pkg::PIX_W-1:0] luma,
    output logic [b2i_pkg::PIX_W-1:0] cb,
    output logic [b2i_pkg::PIX_W-1:0] cr
);

    localparam int W = b2i_pkg::CSC_W;
    localparam int P = b2i_pkg::PIX_W;

    logic signed [W-1:0] r_s;
    logic signed [W-1:0] g_s;
    logic signed [W-1:0] b_s;
    logic signed [W-1:0] y_sum;
    logic signed [W-1:0] cb_sum;
    logic signed [W-1:0] cr_sum;

    assign r_s = signed'(W'(red));
    assign g_s = signed'(W'(green));
    assign b_s = signed'(W'(blue));

    assign y_sum  = W'(b2i_pkg::Y_KR) * r_s + W'(b2i_pkg::Y_KG) * g_s
                  + W'(b2i_pkg::Y_KB) * b_s
                  + W'(b2i_pkg::ROUND + (b2i_pkg::Y_BIAS << P));
    assign cb_sum = W'(b2i_pkg::CB_KR) * r_s + W'(b2i_pkg::CB_KG) * g_s
                  + W'(b2i_pkg::CB_KB) * b_s
                  + W'(b2i_pkg::ROUND + (b2i_pkg::C_BIAS << P));
    assign cr_sum = W'(b2i_pkg::CR_KR) * r_s + W'(b2i_pkg::CR_KG) * g_s
                  + W'(b2i_pkg::CR_KB) * b_s
                  + W'(b2i_pkg::ROUND + (b2i_pkg::C_BIAS << P));

    assign luma = y_sum[2*P-1:P];
    assign cb   = cb_sum[2*P-1:P];
    assign cr   = cr_sum[2*P-1:P];

endmodule

// ----- rtl/b2i_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2i_mul
// Shared registered multiplier; keeps the low product bits.
// ----------------------------------------------------------------------------
module b2i_mul (
    input  logic                         clk,
    input  logic                         en,
    input  logic [b2i_pkg::MUL_A_W-1:0]  a,
    input  logic [b2i_pkg::MUL_B_W-1:0]  b,
    output logic [b2i_pkg::MUL_A_W-1:0]  prod
);

    localparam int FULL_W = b2i_pkg::MUL_A_W + b2i_pkg::MUL_B_W;

    logic [FULL_W-1:0]           full;
    logic [b2i_pkg::MUL_A_W-1:0] prod_reg;

    assign full = FULL_W'(a) * FULL_W'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= full[b2i_pkg::MUL_A_W-1:0];
        end
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/b2i_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2i_div
// Shared restoring divider, several quotient bits per cycle.
// ----------------------------------------------------------------------------
module b2i_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  b2i_pkg::div_req_t            req,
    output logic                         done,
    output logic [b2i_pkg::DIVD_W-1:0]   quotient
);

    localparam int PW = b2i_pkg::DIV_PAD_W;
    localparam int SW = b2i_pkg::DIVS_W;
    localparam int CW = b2i_pkg::DIV_CNT_W;

    logic [SW-1:0] rem_reg;
    logic [SW-1:0] rem_next;
    logic [PW-1:0] quo_reg;
    logic [PW-1:0] quo_next;
    logic [SW-1:0] dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    always_comb
    begin
        logic [SW:0]   t;
        logic [SW-1:0] r;
        logic [PW-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < b2i_pkg::DIV_BITS; i++)
        begin
            t = {r, q[PW-1]};
            q = {q[PW-2:0], 1'b0};
            if (t >= {1'b0, dsr_reg})
            begin
                t    = t - {1'b0, dsr_reg};
                q[0] = 1'b1;
            end
            r = t[SW-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(b2i_pkg::DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= PW'(req.dividend);
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[b2i_pkg::DIVD_W-1:0];

endmodule

// ----- rtl/bgra_to_i420_nearest_scaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgra_to_i420_nearest_scaler
// Fetch engine that scales a BGRA frame into 4:2:0 YCbCr samples.
// ----------------------------------------------------------------------------
// A start beat returns the first fetch offset; each pixel beat returns one
// converted sample and the next fetch offset (the last pixel flags
// frame_done instead), luma plane first, then one Cb/Cr pair per 2x2 block.
// The request port is free again once a beat's result leaves ST_OUT: a start
// or stray-pixel beat goes straight there, the frame's last pixel through
// ST_MDEST and ST_MY, and every other pixel also through two 26-bit divisions
// on the one shared 4-bit-per-cycle divider, with the destination index, both
// products and the row offset made on one shared multiplier. The result sits
// in an output register, so the next beat is taken while it waits.
// ----------------------------------------------------------------------------
module bgra_to_i420_nearest_scaler (
    input  logic                            clk,
    input  logic                            rst_n,
    b2i_req_if.sink                         req,
    b2i_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [b2i_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [b2i_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int DW = b2i_pkg::DIM_W;
    localparam int CN = b2i_pkg::CNT_W;
    localparam int SP = b2i_pkg::STRIDE_W;
    localparam int OW = b2i_pkg::OFF_W;
    localparam int IW = b2i_pkg::IDX_W;
    localparam int PX = b2i_pkg::PIX_W;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_LUMA   = 2'd1;
    localparam logic [1:0] PH_CHROMA = 2'd2;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MDEST = 4'd1;
    localparam logic [3:0] ST_MY    = 4'd2;
    localparam logic [3:0] ST_DY    = 4'd3;
    localparam logic [3:0] ST_DYW   = 4'd4;
    localparam logic [3:0] ST_DX    = 4'd5;
    localparam logic [3:0] ST_DXW   = 4'd6;
    localparam logic [3:0] ST_MS    = 4'd7;
    localparam logic [3:0] ST_SUM   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
        if (v == '0)
        begin
            return DW'(1);
        end
        if (v > DW'(b2i_pkg::MAX_DIM))
        begin
            return DW'(b2i_pkg::MAX_DIM);
        end
        return v;
    endfunction

    // configuration
    logic [DW-1:0] src_width_reg;
    logic [DW-1:0] src_height_reg;
    logic [SP-1:0] src_stride_reg;
    logic [DW-1:0] dst_width_reg;
    logic [DW-1:0] dst_height_reg;

    // frame state
    logic [3:0]    state_reg,  state_next;
    logic [1:0]    phase_reg,  phase_next;
    logic [CN-1:0] col_reg,    col_next;
    logic [CN-1:0] row_reg,    row_next;
    logic          pend_reg,   pend_next;

    // per-beat work
    logic [CN-1:0] dst_col_reg;
    logic [CN-1:0] dst_row_reg;
    logic [DW-1:0] pw_reg;
    logic [DW-1:0] fx_reg;
    logic [DW-1:0] fy_reg;
    logic          fin_reg;
    logic [OW-1:0] srow_reg;
    logic [OW-1:0] scol_reg;

    // pending result
    logic          res_sv_reg;
    logic          res_plane_reg;
    logic [IW-1:0] res_dest_reg;
    logic [PX-1:0] res_luma_reg;
    logic [PX-1:0] res_cb_reg;
    logic [PX-1:0] res_cr_reg;
    logic          res_fv_reg;
    logic [OW-1:0] res_off_reg;
    logic          res_done_reg;
    logic          res_unexp_reg;

    // output stage
    logic          out_valid_reg, out_valid_next;
    logic          out_sv_reg;
    logic          out_plane_reg;
    logic [IW-1:0] out_dest_reg;
    logic [PX-1:0] out_luma_reg;
    logic [PX-1:0] out_cb_reg;
    logic [PX-1:0] out_cr_reg;
    logic          out_fv_reg;
    logic [OW-1:0] out_off_reg;
    logic          out_done_reg;
    logic          out_unexp_reg;

    logic [DW-1:0] sw_c, sh_c, dw_c, dh_c, cw_c, ch_c;
    logic [SP-1:0] sp_c;
    logic          in_acc;
    logic          stray;
    logic          sample_acc;
    logic          is_chroma;
    logic [DW-1:0] pw, ph;
    logic [DW-1:0] col_inc;
    logic          wrap;
    logic [DW-1:0] col_n, row_n;
    logic          row_end, empty_c, fin, to_chroma, new_chroma;
    logic [CN-1:0] col_new, row_new;
    logic          slot_free;
    logic [PX-1:0] csc_y, csc_cb, csc_cr;

    logic                          mul_en;
    logic [b2i_pkg::MUL_A_W-1:0]   mul_a;
    logic [b2i_pkg::MUL_B_W-1:0]   mul_b;
    logic [b2i_pkg::MUL_A_W-1:0]   prod;
    b2i_pkg::div_req_t             div_req;
    logic                          div_done;
    logic [b2i_pkg::DIVD_W-1:0]    div_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= DW'(800);
            src_height_reg <= DW'(480);
            src_stride_reg <= SP'(3200);
            dst_width_reg  <= DW'(400);
            dst_height_reg <= DW'(240);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                b2i_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data[DW-1:0];
                b2i_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data[DW-1:0];
                b2i_pkg::REG_SRC_STRIDE: src_stride_reg <= cfg_data[SP-1:0];
                b2i_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg_data[DW-1:0];
                b2i_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg_data[DW-1:0];
                default:                 ;
            endcase
        end
    end

    assign sw_c = clamp_dim(src_width_reg);
    assign sh_c = clamp_dim(src_height_reg);
    assign dw_c = clamp_dim(dst_width_reg);
    assign dh_c = clamp_dim(dst_height_reg);
    assign cw_c = {1'b0, dw_c[DW-1:1]};
    assign ch_c = {1'b0, dh_c[DW-1:1]};
    assign sp_c = (src_stride_reg > SP'(b2i_pkg::MAX_STRIDE)) ?
                  SP'(b2i_pkg::MAX_STRIDE) : src_stride_reg;

    assign req.ready  = (state_reg == ST_IDLE);
    assign in_acc     = req.valid && req.ready;
    assign stray      = !pend_reg || (phase_reg == PH_IDLE);
    assign sample_acc = (req.op == b2i_pkg::OP_PIXEL) && !stray;

    // next raster position
    assign is_chroma  = (phase_reg == PH_CHROMA);
    assign pw         = is_chroma ? cw_c : dw_c;
    assign ph         = is_chroma ? ch_c : dh_c;
    assign col_inc    = DW'(col_reg) + DW'(1);
    assign wrap       = (col_inc >= pw);
    assign col_n      = wrap ? '0 : col_inc;
    assign row_n      = wrap ? DW'(row_reg) + DW'(1) : DW'(row_reg);
    assign row_end    = (row_n >= ph);
    assign empty_c    = (cw_c == '0) || (ch_c == '0);
    assign fin        = row_end && (is_chroma || empty_c);
    assign to_chroma  = row_end && !is_chroma && !empty_c;
    assign new_chroma = to_chroma || (is_chroma && !fin);
    assign col_new    = row_end ? '0 : col_n[CN-1:0];
    assign row_new    = row_end ? '0 : row_n[CN-1:0];

    b2i_csc u_csc (
        .red   (req.red),
        .green (req.green),
        .blue  (req.blue),
        .luma  (csc_y),
        .cb    (csc_cb),
        .cr    (csc_cr)
    );

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pend_next  = pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (req.op == b2i_pkg::OP_START)
                    begin
                        phase_next = PH_LUMA;
                        col_next   = '0;
                        row_next   = '0;
                        pend_next  = 1'b1;
                        state_next = ST_OUT;
                    end
                    else if (stray)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        col_next   = col_new;
                        row_next   = row_new;
                        if (fin)
                        begin
                            phase_next = PH_IDLE;
                            pend_next  = 1'b0;
                        end
                        else if (to_chroma)
                        begin
                            phase_next = PH_CHROMA;
                        end
                        state_next = ST_MDEST;
                    end
                end
            end
            ST_MDEST: state_next = ST_MY;
            ST_MY:    state_next = fin_reg ? ST_OUT : ST_DY;
            ST_DY:    state_next = ST_DYW;
            ST_DYW:   state_next = div_done ? ST_DX : ST_DYW;
            ST_DX:    state_next = ST_DXW;
            ST_DXW:   state_next = div_done ? ST_MS : ST_DXW;
            ST_MS:    state_next = ST_SUM;
            ST_SUM:   state_next = ST_OUT;
            ST_OUT:   state_next = slot_free ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            pend_reg  <= pend_next;
        end
    end

    // shared multiplier operands
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_MDEST:
            begin
                mul_en = 1'b1;
                mul_a  = b2i_pkg::MUL_A_W'(dst_row_reg);
                mul_b  = b2i_pkg::MUL_B_W'(pw_reg);
            end
            ST_MY:
            begin
                mul_en = 1'b1;
                mul_a  = b2i_pkg::MUL_A_W'(fy_reg);
                mul_b  = b2i_pkg::MUL_B_W'(sh_c);
            end
            ST_DY:
            begin
                mul_en = 1'b1;
                mul_a  = b2i_pkg::MUL_A_W'(fx_reg);
                mul_b  = b2i_pkg::MUL_B_W'(sw_c);
            end
            ST_MS:
            begin
                mul_en = 1'b1;
                mul_a  = srow_reg;
                mul_b  = sp_c;
            end
            default: ;
        endcase
    end

    b2i_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign div_req.start    = (state_reg == ST_DY) || (state_reg == ST_DX);
    assign div_req.dividend = prod;
    assign div_req.divisor  = (state_reg == ST_DX) ? dw_c : dh_c;

    b2i_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            res_sv_reg    <= sample_acc;
            res_plane_reg <= sample_acc && is_chroma;
            res_dest_reg  <= '0;
            res_luma_reg  <= (sample_acc && !is_chroma) ? csc_y : '0;
            res_cb_reg    <= (sample_acc && is_chroma) ? csc_cb : '0;
            res_cr_reg    <= (sample_acc && is_chroma) ? csc_cr : '0;
            res_fv_reg    <= (req.op == b2i_pkg::OP_START) || (sample_acc && !fin);
            res_off_reg   <= '0;
            res_done_reg  <= sample_acc && fin;
            res_unexp_reg <= (req.op == b2i_pkg::OP_PIXEL) && stray;
            dst_col_reg   <= col_reg;
            dst_row_reg   <= row_reg;
            pw_reg        <= pw;
            fx_reg        <= new_chroma ? {col_new, 1'b0} : DW'(col_new);
            fy_reg        <= new_chroma ? {row_new, 1'b0} : DW'(row_new);
            fin_reg       <= fin;
        end
        if (state_reg == ST_MY)
        begin
            res_dest_reg <= prod[IW-1:0] + IW'(dst_col_reg);
        end
        if ((state_reg == ST_DYW) && div_done)
        begin
            srow_reg <= div_q;
        end
        if ((state_reg == ST_DXW) && div_done)
        begin
            scol_reg <= div_q;
        end
        if (state_reg == ST_SUM)
        begin
            res_off_reg <= prod + {scol_reg[OW-3:0], 2'b00};
        end
    end

    // output register
    assign slot_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == ST_OUT) && slot_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && slot_free)
        begin
            out_sv_reg    <= res_sv_reg;
            out_plane_reg <= res_plane_reg;
            out_dest_reg  <= res_dest_reg;
            out_luma_reg  <= res_luma_reg;
            out_cb_reg    <= res_cb_reg;
            out_cr_reg    <= res_cr_reg;
            out_fv_reg    <= res_fv_reg;
            out_off_reg   <= res_off_reg;
            out_done_reg  <= res_done_reg;
            out_unexp_reg <= res_unexp_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.sample_valid = out_sv_reg;
    assign rsp.plane        = out_plane_reg;
    assign rsp.dest_index   = out_dest_reg;
    assign rsp.luma         = out_luma_reg;
    assign rsp.cb           = out_cb_reg;
    assign rsp.cr           = out_cr_reg;
    assign rsp.fetch_valid  = out_fv_reg;
    assign rsp.fetch_offset = out_off_reg;
    assign rsp.frame_done   = out_done_reg;
    assign rsp.unexpected   = out_unexp_reg;

endmodule

// ----- verif/tb_bgra_to_i420_nearest_scaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bgra_to_i420_nearest_scaler
// Self-checking bench for the BGRA to 4:2:0 nearest-neighbor scaler. A
// scoreboard class tracks the pass, position and register file of the block,
// predicts the sample and next fetch offset of every accepted request beat,
// and compares each result beat field by field. Directed frames cover color
// extremes, restarts, stray pixels, empty chroma planes, clamped register
// values and registers rewritten mid-frame; random frames follow, with
// random idle bursts on both channels and one long result-side stall.
// ----------------------------------------------------------------------------
module tb_bgra_to_i420_nearest_scaler;

    localparam int     ITEMS_TARGET  = 1050;
    localparam int     WIND_DOWN_AT  = 900;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     TAIL_CYCLES   = 40;
    localparam int     FRAME_CAP     = 300;
    localparam int     HOLD_AFTER    = 300;
    localparam int     HOLD_CYCLES   = 400;
    localparam longint TIMEOUT_NS    = 3_000_000;

    typedef enum logic [1:0] {PASS_IDLE, PASS_LUMA, PASS_CHROMA} pass_t;

    typedef struct packed {
        logic                        sample_valid;
        logic                        plane;
        logic [b2i_pkg::IDX_W-1:0]   dest_index;
        logic [b2i_pkg::PIX_W-1:0]   luma;
        logic [b2i_pkg::PIX_W-1:0]   cb;
        logic [b2i_pkg::PIX_W-1:0]   cr;
        logic                        fetch_valid;
        logic [b2i_pkg::OFF_W-1:0]   fetch_offset;
        logic                        frame_done;
        logic                        unexpected;
    } scaler_beat_t;

    class scaler_scoreboard;
        logic [12:0]   src_w;
        logic [12:0]   src_h;
        logic [14:0]   stride;
        logic [12:0]   dst_w;
        logic [12:0]   dst_h;
        pass_t         phase;
        int unsigned   col;
        int unsigned   row;
        bit            fetch_out;
        scaler_beat_t  due_beats[$];
        int unsigned   errors;
        int unsigned   beats_checked;
        int unsigned   luma_seen;
        int unsigned   chroma_seen;
        int unsigned   frames_seen;
        int unsigned   strays_seen;

        function new();
            src_w     = 13'd800;
            src_h     = 13'd480;
            stride    = 15'd3200;
            dst_w     = 13'd400;
            dst_h     = 13'd240;
            phase     = PASS_IDLE;
            col       = 0;
            row       = 0;
            fetch_out = 1'b0;
        endfunction

        function void write_reg(logic [b2i_pkg::CFG_IDX_W-1:0] idx, int val);
            case (idx)
                b2i_pkg::REG_SRC_WIDTH:  src_w  = 13'(val);
                b2i_pkg::REG_SRC_HEIGHT: src_h  = 13'(val);
                b2i_pkg::REG_SRC_STRIDE: stride = 15'(val);
                b2i_pkg::REG_DST_WIDTH:  dst_w  = 13'(val);
                b2i_pkg::REG_DST_HEIGHT: dst_h  = 13'(val);
                default: ;
            endcase
        endfunction

        function longint unsigned clamp_dim(logic [12:0] v);
            if (v == 0)
                return 1;
            if (v > b2i_pkg::MAX_DIM)
                return b2i_pkg::MAX_DIM;
            return v;
        endfunction

        function logic [b2i_pkg::OFF_W-1:0] source_offset(longint unsigned c,
                                                          longint unsigned r,
                                                          bit chroma);
            longint unsigned x;
            longint unsigned y;
            longint unsigned sp;
            sp = (stride > b2i_pkg::MAX_STRIDE) ? b2i_pkg::MAX_STRIDE : stride;
            x  = chroma ? 2 * c : c;
            y  = chroma ? 2 * r : r;
            return b2i_pkg::OFF_W'((y * clamp_dim(src_h) / clamp_dim(dst_h)) * sp
                                   + (x * clamp_dim(src_w) / clamp_dim(dst_w)) * 4);
        endfunction

        function logic [7:0] csc(int kr, int kg, int kb, int bias,
                                 logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int s;
            s = kr * int'(r) + kg * int'(g) + kb * int'(b) + 128 + bias * 256;
            return s[15:8];
        endfunction

        // returns 1 when the beat was consumed by a start or a frame in flight
        function bit note_beat(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
            scaler_beat_t    want;
            longint unsigned dw;
            longint unsigned dh;
            longint unsigned cw;
            longint unsigned ch;
            longint unsigned c;
            longint unsigned rw;
            bit              done;
            bit              taken;
            want  = '0;
            dw    = clamp_dim(dst_w);
            dh    = clamp_dim(dst_h);
            cw    = dw / 2;
            ch    = dh / 2;
            c     = col;
            rw    = row;
            done  = 1'b0;
            taken = 1'b1;
            if (op == b2i_pkg::OP_START)
            begin
                phase             = PASS_LUMA;
                col               = 0;
                row               = 0;
                fetch_out         = 1'b1;
                want.fetch_valid  = 1'b1;
                want.fetch_offset = source_offset(0, 0, 1'b0);
            end
            else if (!fetch_out || phase == PASS_IDLE)
            begin
                want.unexpected = 1'b1;
                taken           = 1'b0;
            end
            else
            begin
                want.sample_valid = 1'b1;
                if (phase == PASS_LUMA)
                begin
                    want.dest_index = b2i_pkg::IDX_W'(rw * dw + c);
                    want.luma       = csc(66, 129, 25, 16, r, g, b);
                    c++;
                    if (c >= dw)
                    begin
                        c = 0;
                        rw++;
                    end
                    if (rw >= dh)
                    begin
                        if (cw == 0 || ch == 0)
                            done = 1'b1;
                        else
                        begin
                            phase = PASS_CHROMA;
                            c     = 0;
                            rw    = 0;
                        end
                    end
                end
                else
                begin
                    want.plane      = 1'b1;
                    want.dest_index = b2i_pkg::IDX_W'(rw * cw + c);
                    want.cb         = csc(-38, -74, 112, 128, r, g, b);
                    want.cr         = csc(112, -94, -18, 128, r, g, b);
                    c++;
                    if (c >= cw)
                    begin
                        c = 0;
                        rw++;
                    end
                    if (rw >= ch)
                        done = 1'b1;
                end
                if (done)
                begin
                    want.frame_done = 1'b1;
                    phase           = PASS_IDLE;
                    fetch_out       = 1'b0;
                    col             = 0;
                    row             = 0;
                end
                else
                begin
                    col               = int'(c);
                    row               = int'(rw);
                    want.fetch_valid  = 1'b1;
                    want.fetch_offset = source_offset(c, rw, phase == PASS_CHROMA);
                end
            end
            due_beats.push_back(want);
            return taken;
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task cmp(string name, logic [b2i_pkg::OFF_W-1:0] got,
                 logic [b2i_pkg::OFF_W-1:0] want);
            if (got !== want)
                report($sformatf("beat %0d %s got 0x%0h want 0x%0h",
                                 beats_checked, name, got, want));
        endtask

        task check_beat(scaler_beat_t got);
            scaler_beat_t want;
            if (due_beats.size() == 0)
            begin
                report("result beat with no request outstanding");
                return;
            end
            want = due_beats.pop_front();
            cmp("sample_valid", got.sample_valid, want.sample_valid);
            cmp("plane",        got.plane,        want.plane);
            cmp("dest_index",   got.dest_index,   want.dest_index);
            cmp("luma",         got.luma,         want.luma);
            cmp("cb",           got.cb,           want.cb);
            cmp("cr",           got.cr,           want.cr);
            cmp("fetch_valid",  got.fetch_valid,  want.fetch_valid);
            cmp("fetch_offset", got.fetch_offset, want.fetch_offset);
            cmp("frame_done",   got.frame_done,   want.frame_done);
            cmp("unexpected",   got.unexpected,   want.unexpected);
            beats_checked++;
            if (want.sample_valid)
            begin
                if (want.plane)
                    chroma_seen++;
                else
                    luma_seen++;
            end
            if (want.frame_done)
                frames_seen++;
            if (want.unexpected)
                strays_seen++;
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [b2i_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [b2i_pkg::CFG_DATA_W-1:0] cfg_data;

    b2i_req_if req ();
    b2i_rsp_if rsp ();

    scaler_scoreboard board = new();

    int unsigned items_done;
    int unsigned phases;
    int unsigned tx_gap_pct;
    bit          wind_down;
    bit          hold_done;
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned quiet_left;

    bgra_to_i420_nearest_scaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic send_beat(input logic op, input logic [7:0] b, input logic [7:0] g,
                             input logic [7:0] r);
        if (!wind_down && $urandom_range(0, 99) < tx_gap_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.op    <= op;
        req.blue  <= b;
        req.green <= g;
        req.red   <= r;
        forever
        begin
            @(posedge clk);
            if (req.ready)
                break;
        end
        if (board.note_beat(op, b, g, r))
            items_done++;
    endtask

    task automatic send_pixel();
        send_beat(b2i_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic finish_frame();
        int n;
        n = 0;
        while (board.phase != PASS_IDLE && n < FRAME_CAP)
        begin
            send_pixel();
            n++;
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (board.due_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [b2i_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= b2i_pkg::CFG_DATA_W'(val);
        @(posedge clk);
        board.write_reg(idx, val);
    endtask

    task automatic set_config(input int sw, input int sh, input int sp, input int dw,
                              input int dh);
        put_reg(b2i_pkg::REG_SRC_WIDTH, sw);
        put_reg(b2i_pkg::REG_SRC_HEIGHT, sh);
        put_reg(b2i_pkg::REG_SRC_STRIDE, sp);
        put_reg(b2i_pkg::REG_DST_WIDTH, dw);
        put_reg(b2i_pkg::REG_DST_HEIGHT, dh);
        cfg_we <= 1'b0;
        phases++;
    endtask

    task automatic pick_config();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            // raw register values, out of range and with upper bits set
            set_config(int'($urandom_range(0, 32767)), int'($urandom_range(0, 32767)),
                       int'($urandom_range(0, 32767)),
                       ($urandom_range(0, 3) == 0) ? 8191 : int'($urandom_range(0, 40)),
                       int'($urandom_range(0, 3)));
        end
        else if (sel == 1)
        begin
            set_config(int'($urandom_range(1, 4096)), int'($urandom_range(1, 4096)),
                       int'($urandom_range(4, 16384)), int'($urandom_range(9, 40)),
                       int'($urandom_range(1, 3)));
        end
        else
        begin
            set_config(int'($urandom_range(1, 64)), int'($urandom_range(1, 64)),
                       int'($urandom_range(4, 512)), int'($urandom_range(1, 8)),
                       int'($urandom_range(1, 8)));
        end
        tx_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            board.check_beat('{rsp.sample_valid, rsp.plane, rsp.dest_index, rsp.luma,
                               rsp.cb, rsp.cr, rsp.fetch_valid, rsp.fetch_offset,
                               rsp.frame_done, rsp.unexpected});
    end

    initial
    begin
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
                hold_left--;
            else if (!hold_done && board.beats_checked >= HOLD_AFTER && req.valid)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            else if (stall_left > 0)
                stall_left--;
            else if (quiet_left > 0)
                quiet_left--;
            else if (!wind_down)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    stall_left = $urandom_range(1, 6);
                    2:       quiet_left = $urandom_range(20, 120);
                    default: ;
                endcase
            end
            rsp.ready <= (hold_left == 0 && stall_left == 0);
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout: %0d result beats still outstanding", board.due_beats.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int mode;
        int wait_left;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        req.valid <= 1'b0;
        req.op    <= b2i_pkg::OP_START;
        req.blue  <= '0;
        req.green <= '0;
        req.red   <= '0;
        tx_gap_pct = 25;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray pixel, then a frame at the reset geometry, restarted while busy
        send_beat(b2i_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
        send_beat(b2i_pkg::OP_START, 8'hFF, 8'hFF, 8'hFF);
        send_beat(b2i_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_beat(b2i_pkg::OP_PIXEL, 8'h55, 8'hAA, 8'h55);
        send_beat(b2i_pkg::OP_START, 8'h00, 8'h00, 8'h00);
        send_beat(b2i_pkg::OP_PIXEL, 8'hAA, 8'h55, 8'hAA);
        drain();

        // complete 2x2 frame with both planes, then a stray pixel
        set_config(4, 4, 16, 2, 2);
        send_beat(b2i_pkg::OP_START, 8'h00, 8'h00, 8'h00);
        send_beat(b2i_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'h00);
        send_beat(b2i_pkg::OP_PIXEL, 8'h00, 8'hFF, 8'h00);
        send_beat(b2i_pkg::OP_PIXEL, 8'h00, 8'h00, 8'hFF);
        send_beat(b2i_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
        send_beat(b2i_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_beat(b2i_pkg::OP_PIXEL, 8'h12, 8'h34, 8'h56);
        drain();

        // one-row destination: no chroma plane
        set_config(3, 5, 12, 3, 1);
        send_beat(b2i_pkg::OP_START, 8'h00, 8'h00, 8'h00);
        finish_frame();
        drain();

        // largest raw values, clamped on use
        set_config(8191, 8191, 32767, 8191, 8191);
        send_beat(b2i_pkg::OP_START, 8'h00, 8'h00, 8'h00);
        send_pixel();
        drain();

        // all-zero registers
        set_config(0, 0, 0, 0, 0);
        send_beat(b2i_pkg::OP_START, 8'h00, 8'h00, 8'h00);
        send_pixel();
        drain();

        // geometry rewritten in the middle of a frame
        set_config(6, 6, 24, 4, 4);
        send_beat(b2i_pkg::OP_START, 8'h00, 8'h00, 8'h00);
        repeat (3) send_pixel();
        drain();
        set_config(6, 6, 24, 2, 2);
        finish_frame();
        drain();

        while (items_done < ITEMS_TARGET)
        begin
            if (items_done >= WIND_DOWN_AT)
                wind_down = 1'b1;
            pick_config();
            repeat ($urandom_range(1, 3))
            begin
                if (items_done >= ITEMS_TARGET)
                    break;
                mode = $urandom_range(0, 19);
                if (mode < 14)
                begin
                    send_beat(b2i_pkg::OP_START, 8'($urandom), 8'($urandom),
                              8'($urandom));
                    finish_frame();
                    if ($urandom_range(0, 5) == 0)
                        send_pixel();
                end
                else if (mode < 16)
                begin
                    send_beat(b2i_pkg::OP_START, 8'($urandom), 8'($urandom),
                              8'($urandom));
                    repeat ($urandom_range(1, 5)) send_pixel();
                end
                else if (mode < 18)
                begin
                    send_beat(b2i_pkg::OP_START, 8'($urandom), 8'($urandom),
                              8'($urandom));
                    repeat ($urandom_range(1, 4)) send_pixel();
                    drain();
                    pick_config();
                    finish_frame();
                end
                else
                begin
                    repeat ($urandom_range(1, 6))
                        send_beat(($urandom_range(0, 3) == 0) ? b2i_pkg::OP_START
                                                              : b2i_pkg::OP_PIXEL,
                                  8'($urandom), 8'($urandom), 8'($urandom));
                end
            end
            drain();
        end

        req.valid <= 1'b0;
        wait_left = 2000;
        while (board.due_beats.size() != 0 && wait_left > 0)
        begin
            @(posedge clk);
            wait_left--;
        end
        if (board.due_beats.size() != 0)
            board.report($sformatf("%0d result beats never arrived",
                                   board.due_beats.size()));
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d result beats: %0d luma, %0d chroma, %0d stray, %0d frames",
                 board.beats_checked, board.luma_seen, board.chroma_seen,
                 board.strays_seen, board.frames_seen);
        $display("Register settings: %0d, long output stall applied: %0d, mismatches: %0d",
                 phases, hold_done, board.errors);
        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/b2i_pkg.sv
rtl/b2i_ifs.sv
rtl/b2i_csc.sv
rtl/b2i_mul.sv
rtl/b2i_div.sv
rtl/bgra_to_i420_nearest_scaler.sv
verif/tb_bgra_to_i420_nearest_scaler.sv
